FILE: rtl/lsia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lsia_pkg;

    localparam int SWITCH_W   = 64;
    localparam int MAC_W      = 48;
    localparam int PORT_W     = 32;
    localparam int ETYPE_W    = 16;
    localparam int IP_W       = 32;
    localparam int MATRIX_W   = 64;
    localparam int ACTION_W   = 3;
    localparam int HOST_IDX_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [ETYPE_W-1:0]    ETH_IPV4     = 16'h0800;
    localparam logic [ETYPE_W-1:0]    ETH_ARP      = 16'h0806;
    localparam logic [MAC_W-1:0]      MAC_BCAST    = 48'hFFFF_FFFF_FFFF;
    localparam logic [IP_W-1:0]       IP_NONE      = 32'h0000_0000;
    localparam logic [IP_W-1:0]       BASE_RESET   = 32'h0A00_0001;
    localparam logic [MATRIX_W-1:0]   MATRIX_RESET = 64'h0000_001C_0C1C_0E1F;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HOST_BASE = 1'b0,
        CFG_MATRIX    = 1'b1
    } t_cfg_idx;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BCAST_SRC = 3'd0,
        ACT_NO_IP     = 3'd1,
        ACT_VIOLATION = 3'd2,
        ACT_UNICAST   = 3'd3,
        ACT_FLOOD     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LEARN,
        ST_LOOK
    } t_state;

    // control from the sequencer to the datapath
    typedef struct packed {
        logic hdr_ready;
        logic learn_en;
        logic key_is_src;
        logic load_out;
    } t_ctrl;

endpackage

`default_nettype wire

FILE: rtl/lsia_hdr_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsia_hdr_if;
    logic                          valid;
    logic                          ready;
    logic [lsia_pkg::SWITCH_W-1:0] switch_id;
    logic [lsia_pkg::MAC_W-1:0]    src_mac;
    logic [lsia_pkg::MAC_W-1:0]    dst_mac;
    logic [lsia_pkg::PORT_W-1:0]   in_port;
    logic [lsia_pkg::ETYPE_W-1:0]  frame_type;
    logic [lsia_pkg::IP_W-1:0]     src_ip;
    logic [lsia_pkg::IP_W-1:0]     dst_ip;

    modport source (
        output valid, switch_id, src_mac, dst_mac, in_port, frame_type, src_ip, dst_ip,
        input  ready
    );
    modport sink (
        input  valid, switch_id, src_mac, dst_mac, in_port, frame_type, src_ip, dst_ip,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/lsia_res_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface lsia_res_if;
    logic                          valid;
    logic                          ready;
    logic [lsia_pkg::ACTION_W-1:0] action;
    logic [lsia_pkg::PORT_W-1:0]   out_port;

    modport source (
        output valid, action, out_port,
        input  ready
    );
    modport sink (
        input  valid, action, out_port,
        output ready
    );
endinterface

`default_nettype wire

FILE: rtl/lsia_cam_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One table entry. Compares the shared key and merges its match into the
// chain that runs to the next cell; keys are unique, so at most one cell hits.
module lsia_cam_cell #(
    parameter int               IDX_W = 6,
    parameter logic [IDX_W-1:0] IDX   = '0
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic                          i_valid,
    input  wire logic [lsia_pkg::SWITCH_W-1:0] i_wr_switch,
    input  wire logic [lsia_pkg::MAC_W-1:0]    i_wr_mac,
    input  wire logic [lsia_pkg::PORT_W-1:0]   i_wr_port,
    input  wire logic [lsia_pkg::SWITCH_W-1:0] i_key_switch,
    input  wire logic [lsia_pkg::MAC_W-1:0]    i_key_mac,
    input  wire logic                          i_hit_chain,
    input  wire logic [IDX_W-1:0]              i_idx_chain,
    input  wire logic [lsia_pkg::PORT_W-1:0]   i_port_chain,
    output logic                               o_hit_chain,
    output logic [IDX_W-1:0]                   o_idx_chain,
    output logic [lsia_pkg::PORT_W-1:0]        o_port_chain
);

    logic [lsia_pkg::SWITCH_W-1:0] r_switch;
    logic [lsia_pkg::MAC_W-1:0]    r_mac;
    logic [lsia_pkg::PORT_W-1:0]   r_port;
    logic                          w_hit;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_switch <= i_wr_switch;
            r_mac    <= i_wr_mac;
            r_port   <= i_wr_port;
        end
    end

    assign w_hit        = i_valid && (r_switch == i_key_switch) && (r_mac == i_key_mac);
    assign o_hit_chain  = i_hit_chain | w_hit;
    assign o_idx_chain  = i_idx_chain | (w_hit ? IDX : '0);
    assign o_port_chain = i_port_chain | (w_hit ? r_port : '0);

endmodule

`default_nettype wire

FILE: rtl/lsia_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: learn, then lookup; loads the result once output is free.
module lsia_seq (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_hdr_valid,
    input  wire logic          i_out_free,
    input  wire logic          i_src_bcast,
    output lsia_pkg::t_ctrl    o_ctrl
);

    lsia_pkg::t_state r_state;
    lsia_pkg::t_state n_state;
    logic             w_take;

    assign w_take = o_ctrl.hdr_ready && i_hdr_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsia_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lsia_pkg::ST_IDLE: begin
                if (w_take) n_state = lsia_pkg::ST_LEARN;
            end
            lsia_pkg::ST_LEARN: begin
                n_state = lsia_pkg::ST_LOOK;
            end
            lsia_pkg::ST_LOOK: begin
                if (i_out_free) n_state = w_take ? lsia_pkg::ST_LEARN : lsia_pkg::ST_IDLE;
            end
            default: begin
                n_state = lsia_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        case (r_state)
            lsia_pkg::ST_IDLE: begin
                o_ctrl.hdr_ready = 1'b1;
            end
            lsia_pkg::ST_LEARN: begin
                o_ctrl.learn_en   = !i_src_bcast;
                o_ctrl.key_is_src = 1'b1;
            end
            lsia_pkg::ST_LOOK: begin
                o_ctrl.load_out  = i_out_free;
                o_ctrl.hdr_ready = i_out_free;
            end
            default: begin
                o_ctrl = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/learning_switch_ip_acl.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload
// i_hdr     in   switch_id, src_mac, dst_mac, in_port, frame_type, src_ip, dst_ip
// o_res     out  action, out_port
// i_cfg_*   in   write enable, register index, 64-bit data (no read-back)
//
// Each item passes a learn state for the source key into the cell row, then a
// lookup state for the destination key through the chain that loads the result.
// The next header is taken in the lookup cycle when the output register is free.
// Reset empties the table (fill count and replace pointer to zero) and loads
// the register defaults. With the result stalled, headers wait once one is in lookup.
module learning_switch_ip_acl #(
    parameter int TABLE_ENTRIES = 64,
    parameter int ACL_HOSTS     = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    lsia_hdr_if.sink                             i_hdr,
    lsia_res_if.source                           o_res,
    input  wire logic                            i_cfg_we,
    input  wire logic [lsia_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [lsia_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

    lsia_pkg::t_ctrl w_ctrl;

    logic [lsia_pkg::SWITCH_W-1:0] r_sw;
    logic [lsia_pkg::MAC_W-1:0]    r_smac;
    logic [lsia_pkg::MAC_W-1:0]    r_dmac;
    logic [lsia_pkg::PORT_W-1:0]   r_port;
    logic [lsia_pkg::ETYPE_W-1:0]  r_etype;
    logic [lsia_pkg::IP_W-1:0]     r_sip;
    logic [lsia_pkg::IP_W-1:0]     r_dip;

    logic [lsia_pkg::IP_W-1:0]     r_base;
    logic [lsia_pkg::MATRIX_W-1:0] r_matrix;
    logic [FILL_W-1:0]             r_fill;
    logic [IDX_W-1:0]              r_rptr;

    logic                          r_out_valid;
    lsia_pkg::t_action             r_action;
    logic [lsia_pkg::PORT_W-1:0]   r_out_port;

    logic                          w_out_free;
    logic                          w_take;
    logic                          w_src_bcast;
    logic [lsia_pkg::MAC_W-1:0]    w_key_mac;
    logic [IDX_W-1:0]              w_slot;
    logic [TABLE_ENTRIES-1:0]      w_valid;
    logic [TABLE_ENTRIES-1:0]      w_we;

    logic                          w_hit_chain  [TABLE_ENTRIES+1];
    logic [IDX_W-1:0]              w_idx_chain  [TABLE_ENTRIES+1];
    logic [lsia_pkg::PORT_W-1:0]   w_port_chain [TABLE_ENTRIES+1];

    logic                          w_ip_frame;
    logic [lsia_pkg::IP_W-1:0]     w_sip;
    logic [lsia_pkg::IP_W-1:0]     w_dip;
    logic [lsia_pkg::IP_W-1:0]     w_si;
    logic [lsia_pkg::IP_W-1:0]     w_di;
    logic                          w_in_range;
    logic                          w_allowed;
    lsia_pkg::t_action             w_action;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_take      = i_hdr.valid && i_hdr.ready;
    assign w_src_bcast = (r_smac == lsia_pkg::MAC_BCAST);
    // hold the header side off while reset is applied
    assign i_hdr.ready = w_ctrl.hdr_ready && i_rst_n;

    lsia_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr_valid (i_hdr.valid),
        .i_out_free  (w_out_free),
        .i_src_bcast (w_src_bcast),
        .o_ctrl      (w_ctrl)
    );

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_sw    <= i_hdr.switch_id;
            r_smac  <= i_hdr.src_mac;
            r_dmac  <= i_hdr.dst_mac;
            r_port  <= i_hdr.in_port;
            r_etype <= i_hdr.frame_type;
            r_sip   <= i_hdr.src_ip;
            r_dip   <= i_hdr.dst_ip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= lsia_pkg::BASE_RESET;
            r_matrix <= lsia_pkg::MATRIX_RESET;
        end else if (i_cfg_we) begin
            case (lsia_pkg::t_cfg_idx'(i_cfg_idx))
                lsia_pkg::CFG_HOST_BASE: r_base   <= i_cfg_data[lsia_pkg::IP_W-1:0];
                lsia_pkg::CFG_MATRIX:    r_matrix <= i_cfg_data;
                default: begin
                    r_base <= r_base;
                end
            endcase
        end
    end

    // key bus: source key in the learn cycle, destination key in the lookup cycle
    assign w_key_mac = w_ctrl.key_is_src ? r_smac : r_dmac;

    assign w_hit_chain[0]  = 1'b0;
    assign w_idx_chain[0]  = '0;
    assign w_port_chain[0] = '0;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        assign w_valid[g] = (r_fill > FILL_W'(g));
        assign w_we[g]    = w_ctrl.learn_en && (w_slot == IDX_W'(g));

        lsia_cam_cell #(
            .IDX_W (IDX_W),
            .IDX   (IDX_W'(g))
        ) u_cell (
            .i_clk        (i_clk),
            .i_we         (w_we[g]),
            .i_valid      (w_valid[g]),
            .i_wr_switch  (r_sw),
            .i_wr_mac     (r_smac),
            .i_wr_port    (r_port),
            .i_key_switch (r_sw),
            .i_key_mac    (w_key_mac),
            .i_hit_chain  (w_hit_chain[g]),
            .i_idx_chain  (w_idx_chain[g]),
            .i_port_chain (w_port_chain[g]),
            .o_hit_chain  (w_hit_chain[g+1]),
            .o_idx_chain  (w_idx_chain[g+1]),
            .o_port_chain (w_port_chain[g+1])
        );
    end

    // hit: rewrite in place; miss: next free entry, else round-robin victim
    always_comb begin
        if (w_hit_chain[TABLE_ENTRIES]) begin
            w_slot = w_idx_chain[TABLE_ENTRIES];
        end else if (r_fill < FILL_W'(TABLE_ENTRIES)) begin
            w_slot = r_fill[IDX_W-1:0];
        end else begin
            w_slot = r_rptr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_rptr <= '0;
        end else if (w_ctrl.learn_en && !w_hit_chain[TABLE_ENTRIES]) begin
            if (r_fill < FILL_W'(TABLE_ENTRIES)) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (r_rptr == IDX_W'(TABLE_ENTRIES - 1)) begin
                r_rptr <= '0;
            end else begin
                r_rptr <= r_rptr + IDX_W'(1);
            end
        end
    end

    assign w_ip_frame = (r_etype == lsia_pkg::ETH_IPV4) || (r_etype == lsia_pkg::ETH_ARP);
    assign w_sip      = w_ip_frame ? r_sip : lsia_pkg::IP_NONE;
    assign w_dip      = w_ip_frame ? r_dip : lsia_pkg::IP_NONE;
    assign w_si       = w_sip - r_base;
    assign w_di       = w_dip - r_base;
    assign w_in_range = (w_si < lsia_pkg::IP_W'(ACL_HOSTS))
                     && (w_di < lsia_pkg::IP_W'(ACL_HOSTS));
    assign w_allowed  = w_in_range
                     && r_matrix[{w_si[lsia_pkg::HOST_IDX_W-1:0],
                                  w_di[lsia_pkg::HOST_IDX_W-1:0]}];

    always_comb begin
        if (w_src_bcast) begin
            w_action = lsia_pkg::ACT_BCAST_SRC;
        end else if (w_sip == lsia_pkg::IP_NONE || w_dip == lsia_pkg::IP_NONE) begin
            w_action = lsia_pkg::ACT_NO_IP;
        end else if (!w_allowed) begin
            w_action = lsia_pkg::ACT_VIOLATION;
        end else if (w_hit_chain[TABLE_ENTRIES]) begin
            w_action = lsia_pkg::ACT_UNICAST;
        end else begin
            w_action = lsia_pkg::ACT_FLOOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctrl.load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctrl.load_out) begin
            r_action   <= w_action;
            r_out_port <= (w_action == lsia_pkg::ACT_UNICAST)
                        ? w_port_chain[TABLE_ENTRIES] : '0;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.action   = r_action;
    assign o_res.out_port = r_out_port;

endmodule

`default_nettype wire
